>>> rtl/i2ra_pkg.sv
// Package for the 64-bit integer to radix ASCII converter.
// Holds the sequencer state type, character constants and the digit mapping.
// No dependencies.
package i2ra_pkg;

  localparam int unsigned ValueW = 64;
  localparam int unsigned RadixW = 6;
  localparam int unsigned CharW = 8;
  localparam int unsigned CountW = $clog2(ValueW);

  localparam logic [RadixW-1:0] RadixMin = RadixW'(2);
  localparam logic [RadixW-1:0] RadixMax = RadixW'(36);
  localparam logic [RadixW-1:0] RadixDec = RadixW'(10);

  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChA     = 8'h61;
  localparam logic [CharW-1:0] ChMinus = 8'h2d;
  localparam logic [CharW-1:0] ChNone  = 8'h00;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BAD,
    ST_SIGN,
    ST_DIV,
    ST_STORE,
    ST_READ,
    ST_SHOW
  } state_t;

  function automatic logic [CharW-1:0] digit_char(input logic [RadixW-1:0] d);
    logic [CharW-1:0] dw;
    dw = {2'b00, d};
    if (d < RadixDec) begin
      return CharW'(ChZero + dw);
    end
    return CharW'(ChA + dw - {2'b00, RadixDec});
  endfunction

endpackage

>>> rtl/int64_to_radix_ascii.sv
// Top level of the 64-bit integer to radix ASCII converter.
// Contains the sequencer, the shared restoring divider and the digit buffer.
// Depends on i2ra_pkg.
//
// Usage: an item (value, is_signed, radix) is taken on the input channel by a
// valid/ready transfer. The block then emits one character per transfer on the
// output channel, most significant digit first, with last set on the final one.
// In radix ten a signed negative value is preceded by a minus sign. A radix
// outside 2 to 36 gives a single transfer with bad_radix and last set and a
// zero character.
// The restoring divider yields one quotient bit per cycle; each digit takes a full
// division pass (ST_DIV) and then a store of the remainder digit (ST_STORE). Each
// character is read from the digit buffer (ST_READ) and then shown (ST_SHOW).
// in_ready is high only while idle, so no new item is taken mid-conversion.
// Reset returns the sequencer to idle and drops out_valid. When the receiver
// stalls, the output register holds its character and the sequencer waits.
module int64_to_radix_ascii (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [i2ra_pkg::ValueW-1:0]   value,
  input  logic                          is_signed,
  input  logic [i2ra_pkg::RadixW-1:0]   radix,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [i2ra_pkg::CharW-1:0]    character,
  output logic                          last,
  output logic                          bad_radix
);
  import i2ra_pkg::*;

  state_t state, state_next;

  logic [ValueW-1:0] quo;
  logic [RadixW-1:0] rem;
  logic [RadixW-1:0] rdx;
  logic [CountW-1:0] bit_cnt;
  logic [CountW:0]   nd;
  logic [CountW-1:0] rd_idx;
  logic [CharW-1:0]  mem_q;
  logic [CharW-1:0]  digit_mem [ValueW];

  logic              in_xfer;
  logic              radix_bad;
  logic              neg;
  logic              out_free;
  logic              out_load;
  logic [CharW-1:0]  load_char;
  logic              load_last;
  logic              load_bad;
  logic [RadixW:0]   trial;
  logic              trial_ge;
  logic [RadixW:0]   trial_diff;

  assign in_xfer   = in_valid && in_ready;
  assign radix_bad = (radix < RadixMin) || (radix > RadixMax);
  assign neg       = (radix == RadixDec) && is_signed && value[ValueW-1];
  assign out_free  = !out_valid || out_ready;

  assign trial      = {rem, quo[ValueW-1]};
  assign trial_ge   = trial >= {1'b0, rdx};
  assign trial_diff = trial - {1'b0, rdx};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          priority if (radix_bad) begin
            state_next = ST_BAD;
          end else if (neg) begin
            state_next = ST_SIGN;
          end else begin
            state_next = ST_DIV;
          end
        end
      end
      ST_BAD: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_SIGN: begin
        if (out_free) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (bit_cnt == CountW'(ValueW - 1)) state_next = ST_STORE;
      end
      ST_STORE: begin
        if (quo == '0) begin
          state_next = ST_READ;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_READ: begin
        state_next = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_free) begin
          if (rd_idx == '0) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    out_load  = 1'b0;
    load_char = ChNone;
    load_last = 1'b0;
    load_bad  = 1'b0;
    unique case (state)
      ST_BAD: begin
        out_load  = out_free;
        load_last = 1'b1;
        load_bad  = 1'b1;
      end
      ST_SIGN: begin
        out_load  = out_free;
        load_char = ChMinus;
      end
      ST_SHOW: begin
        out_load  = out_free;
        load_char = mem_q;
        load_last = (rd_idx == '0);
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          quo     <= neg ? (ValueW'(0) - value) : value;
          rdx     <= radix;
          rem     <= '0;
          bit_cnt <= '0;
          nd      <= '0;
        end
      end
      ST_DIV: begin
        quo     <= {quo[ValueW-2:0], trial_ge};
        rem     <= trial_ge ? trial_diff[RadixW-1:0] : trial[RadixW-1:0];
        bit_cnt <= CountW'(bit_cnt + 1'b1);
      end
      ST_STORE: begin
        nd      <= nd + 1'b1;
        rd_idx  <= nd[CountW-1:0];
        rem     <= '0;
        bit_cnt <= '0;
      end
      ST_SHOW: begin
        if (out_free && rd_idx != '0) begin
          rd_idx <= rd_idx - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_STORE) begin
      digit_mem[nd[CountW-1:0]] <= digit_char(rem);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      mem_q <= digit_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      character <= load_char;
      last      <= load_last;
      bad_radix <= load_bad;
    end
  end

endmodule
